### rtl/core/aes_ctr_pkg.sv
// ----------------------------------------------------------------------------
// AES counter-mode keystream package
// Shared widths, register indexes, S-box and GF(2^8) helpers.
// ----------------------------------------------------------------------------
package aes_ctr_pkg;

  localparam int unsigned AddrW = 6;

  typedef enum logic [2:0] {
    REG_KEY_LOW  = 3'd0,
    REG_KEY_MID  = 3'd1,
    REG_KEY_HIGH = 3'd2,
    REG_KEY_TOP  = 3'd3,
    REG_KEY_LEN  = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    KEY_128 = 2'd0,
    KEY_192 = 2'd1,
    KEY_256 = 2'd2
  } key_len_e;

  typedef struct packed {
    logic       start;
    logic [3:0] nr;
  } core_ctrl_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0: r = 8'h01;
      4'd1: r = 8'h02;
      4'd2: r = 8'h04;
      4'd3: r = 8'h08;
      4'd4: r = 8'h10;
      4'd5: r = 8'h20;
      4'd6: r = 8'h40;
      4'd7: r = 8'h80;
      4'd8: r = 8'h1b;
      default: r = 8'h36;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage

### rtl/core/aes_ctr_if.sv
// ----------------------------------------------------------------------------
// AES counter-mode stream channel
// Valid/ready channel carrying one byte and an end mark per beat.
// ----------------------------------------------------------------------------
interface aes_ctr_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

### rtl/core/aes_ctr_core.sv
// ----------------------------------------------------------------------------
// AES counter-mode round core
// Expands the key word by word, then runs one AES round per cycle.
// ----------------------------------------------------------------------------
module aes_ctr_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  aes_ctr_pkg::core_ctrl_t ctrl_i,
  input  logic [255:0]           key_i,
  input  logic [1:0]             key_len_i,
  input  logic                   expand_i,
  input  logic [63:0]            ctr_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [127:0]           block_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXP  = 4'b0010,
    ST_RND  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e       state_q, state_d;
  logic [127:0] rk_q [15];
  logic [5:0]   wi_q;
  logic [3:0]   nk_q;
  logic [2:0]   wc_q;
  logic [3:0]   ri_q;
  logic [3:0]   rc_q;
  logic [3:0]   nr_q;
  logic [127:0] s_q;
  logic [31:0]  t_w, new_w, prev_w, back_w;
  logic [5:0]   tot_w;
  logic [5:0]   pi_w, bi_w;
  logic [127:0] sr_w, mc_w, rk_w;

  assign busy_o  = (state_q != ST_IDLE) && (state_q != ST_DONE);
  assign done_o  = (state_q == ST_DONE);
  assign block_o = s_q;
  assign tot_w   = 6'((nk_q + 4'd7) * 4);

  assign pi_w   = wi_q - 6'd1;
  assign bi_w   = wi_q - 6'(nk_q);
  assign prev_w = rk_q[pi_w[5:2]][{pi_w[1:0], 5'd0} +: 32];
  assign back_w = rk_q[bi_w[5:2]][{bi_w[1:0], 5'd0} +: 32];

  always_comb begin
    t_w = prev_w;
    if (wc_q == 3'd0) begin
      t_w = aes_ctr_pkg::sub_word({prev_w[7:0], prev_w[31:8]});
      t_w[7:0] = t_w[7:0] ^ aes_ctr_pkg::rcon(rc_q);
    end else if (nk_q == 4'd8 && wc_q == 3'd4) begin
      t_w = aes_ctr_pkg::sub_word(prev_w);
    end
    new_w = back_w ^ t_w;
  end

  assign rk_w = rk_q[ri_q];

  always_comb begin
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        sr_w[(c*4+k)*8 +: 8] = aes_ctr_pkg::sbox(s_q[(((c+k)&3)*4+k)*8 +: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sr_w[(c*4)*8 +: 8];
      a1 = sr_w[(c*4+1)*8 +: 8];
      a2 = sr_w[(c*4+2)*8 +: 8];
      a3 = sr_w[(c*4+3)*8 +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      mc_w[(c*4)*8 +: 8]   = a0 ^ al ^ aes_ctr_pkg::xtime(a0 ^ a1);
      mc_w[(c*4+1)*8 +: 8] = a1 ^ al ^ aes_ctr_pkg::xtime(a1 ^ a2);
      mc_w[(c*4+2)*8 +: 8] = a2 ^ al ^ aes_ctr_pkg::xtime(a2 ^ a3);
      mc_w[(c*4+3)*8 +: 8] = a3 ^ al ^ aes_ctr_pkg::xtime(a3 ^ a0);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (expand_i) state_d = ST_EXP;
        else if (ctrl_i.start) state_d = ST_RND;
      end
      ST_EXP:  if (wi_q == tot_w - 6'd1) state_d = ST_IDLE;
      ST_RND:  if (ri_q == nr_q) state_d = ST_DONE;
      ST_DONE: begin
        if (expand_i) state_d = ST_EXP;
        else if (ctrl_i.start) state_d = ST_RND;
      end
      default: state_d = ST_IDLE;
    endcase
    if (expand_i) state_d = ST_EXP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EXP;
      wi_q    <= 6'd4;
      nk_q    <= 4'd4;
      wc_q    <= 3'd0;
      rc_q    <= 4'd0;
      ri_q    <= 4'd0;
      nr_q    <= 4'd10;
    end else begin
      state_q <= state_d;
      if (expand_i) begin
        nk_q <= (key_len_i == aes_ctr_pkg::KEY_128) ? 4'd4 :
                (key_len_i == aes_ctr_pkg::KEY_192) ? 4'd6 : 4'd8;
        wi_q <= (key_len_i == aes_ctr_pkg::KEY_128) ? 6'd4 :
                (key_len_i == aes_ctr_pkg::KEY_192) ? 6'd6 : 6'd8;
        wc_q <= 3'd0;
        rc_q <= 4'd0;
      end else if (state_q == ST_EXP) begin
        wi_q <= wi_q + 6'd1;
        if (wc_q == 3'(nk_q - 4'd1)) begin
          wc_q <= 3'd0;
          rc_q <= rc_q + 4'd1;
        end else begin
          wc_q <= wc_q + 3'd1;
        end
      end
      if (ctrl_i.start && !expand_i && !busy_o) begin
        ri_q <= 4'd1;
        nr_q <= ctrl_i.nr;
      end else if (state_q == ST_RND) begin
        ri_q <= ri_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 15; i++) rk_q[i] <= 128'd0;
    end else if (expand_i) begin
      rk_q[0] <= key_i[127:0];
      rk_q[1] <= key_i[255:128];
    end else if (state_q == ST_EXP) begin
      rk_q[wi_q[5:2]][{wi_q[1:0], 5'd0} +: 32] <= new_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start && !expand_i && !busy_o) begin
      s_q <= {64'd0, ctr_i} ^ rk_q[0];
    end else if (state_q == ST_RND) begin
      s_q <= ((ri_q == nr_q) ? sr_w : mc_w) ^ rk_w;
    end
  end

  a_rnd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RND |-> ri_q <= nr_q && ri_q != 4'd0)
    else $error("round index out of range");
  a_exp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXP |-> wi_q < tot_w)
    else $error("key word index out of range");
  a_done_after_rnd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(state_q) == ST_RND)
    else $error("done without rounds");

endmodule

### rtl/core/aes_ctr_keystream_xor_unit.sv
// ----------------------------------------------------------------------------
// AES counter-mode keystream XOR unit
// Bytes 1..15 of a block are XORed with the held keystream and registered; the first
// byte of a block starts a refill and is XORed with byte 0 of the new keystream block.
// Throughput: one byte per cycle within a block while the output is ready, input held during a refill.
// Key expansion runs after reset and after a write to a key or key-length register,
// one key word per cycle, input not ready meanwhile.
// Reset: counter 0, position 16, key zero, AES-128, expansion runs.
// ----------------------------------------------------------------------------
module aes_ctr_keystream_xor_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [aes_ctr_pkg::AddrW-1:0]   paddr,
  input  logic [63:0]                     pwdata,
  output logic [63:0]                     prdata,
  output logic                            pready,
  aes_ctr_if.sink                         in_if,
  aes_ctr_if.source                       out_if
);

  logic [63:0]  key_q [4];
  logic [1:0]   klen_q;
  logic [63:0]  ctr_q;
  logic [127:0] ks_q;
  logic [4:0]   pos_q;
  logic         pend_q;
  logic [7:0]   pdata_q;
  logic         plast_q;
  logic         ovalid_q;
  logic [7:0]   obyte_q;
  logic         olast_q;
  logic         wr_w, busy_w, done_w, refill_q;
  logic [2:0]   widx_w;
  logic [127:0] blk_w;
  aes_ctr_pkg::core_ctrl_t ctrl_w;

  assign pready = 1'b1;
  assign wr_w   = psel && penable && pwrite;
  assign widx_w = paddr[5:3];

  always_comb begin
    prdata = 64'd0;
    unique case (widx_w)
      aes_ctr_pkg::REG_KEY_LOW:  prdata = key_q[0];
      aes_ctr_pkg::REG_KEY_MID:  prdata = key_q[1];
      aes_ctr_pkg::REG_KEY_HIGH: prdata = key_q[2];
      aes_ctr_pkg::REG_KEY_TOP:  prdata = key_q[3];
      aes_ctr_pkg::REG_KEY_LEN:  prdata = {62'd0, klen_q};
      default:                   prdata = 64'd0;
    endcase
  end

  logic cfg_hit_w;
  assign cfg_hit_w = wr_w && (widx_w <= aes_ctr_pkg::REG_KEY_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= 64'd0;
      klen_q <= 2'd0;
    end else if (cfg_hit_w) begin
      case (widx_w)
        aes_ctr_pkg::REG_KEY_LEN: klen_q <= pwdata[1:0];
        default:                  key_q[widx_w[1:0]] <= pwdata;
      endcase
    end
  end

  logic kick_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) kick_q <= 1'b0;
    else         kick_q <= cfg_hit_w;
  end

  assign in_if.ready = !pend_q && !kick_q && !busy_w && !cfg_hit_w
                       && (!ovalid_q || out_if.ready);

  logic acc_w;
  assign acc_w = in_if.valid && in_if.ready;

  logic fill_w;
  assign fill_w = pend_q && done_w && !ovalid_q && !cfg_hit_w;

  assign ctrl_w.start = acc_w && (pos_q[4]);
  assign ctrl_w.nr    = (klen_q == aes_ctr_pkg::KEY_128) ? 4'd10 :
                        (klen_q == aes_ctr_pkg::KEY_192) ? 4'd12 : 4'd14;

  aes_ctr_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl_w),
    .key_i     ({key_q[3], key_q[2], key_q[1], key_q[0]}),
    .key_len_i (klen_q),
    .expand_i  (kick_q),
    .ctr_i     (ctr_q + 64'd1),
    .busy_o    (busy_w),
    .done_o    (done_w),
    .block_o   (blk_w)
  );

  logic [127:0] ks_w;
  logic [3:0]   sel_w;
  assign ks_w  = refill_q ? blk_w : ks_q;
  assign sel_w = pos_q[3:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q    <= 64'd0;
      pos_q    <= 5'd16;
      pend_q   <= 1'b0;
      refill_q <= 1'b0;
      ovalid_q <= 1'b0;
      ks_q     <= 128'd0;
    end else begin
      ovalid_q <= (acc_w && !pos_q[4]) || fill_w || (ovalid_q && !out_if.ready);
      refill_q <= fill_w;
      if (cfg_hit_w) begin
        ctr_q <= 64'd0;
        pos_q <= 5'd16;
      end else if (acc_w) begin
        if (pos_q[4]) begin
          pend_q  <= 1'b1;
          ctr_q   <= ctr_q + 64'd1;
          pos_q   <= 5'd0;
        end else begin
          pos_q    <= pos_q + 5'd1;
        end
      end else if (fill_w) begin
        pend_q   <= 1'b0;
        ks_q     <= blk_w;
        pos_q    <= 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_w) begin
      pdata_q <= in_if.data_byte;
      plast_q <= in_if.last;
      if (!pos_q[4]) begin
        obyte_q <= in_if.data_byte ^ ks_w[{sel_w, 3'd0} +: 8];
        olast_q <= in_if.last;
      end
    end else if (pend_q && done_w && !ovalid_q) begin
      obyte_q <= pdata_q ^ blk_w[7:0];
      olast_q <= plast_q;
    end
  end

  assign out_if.valid     = ovalid_q;
  assign out_if.data_byte = obyte_q;
  assign out_if.last      = olast_q;

  a_no_accept_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !in_if.ready)
    else $error("input taken during refill");
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 5'd16)
    else $error("byte position out of range");
  a_refill_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(pend_q) && !$past(cfg_hit_w) |-> ovalid_q)
    else $error("refill lost a beat");

endmodule
